@@ design/tof_zone_sensor_model_macros.svh @@
// Assertion macros used by the ranging sensor model datapath (tzs_dp).
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef TOF_ZONE_SENSOR_MODEL_MACROS_SVH
`define TOF_ZONE_SENSOR_MODEL_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TZS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define TZS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tzs_pkg.sv @@
// Types, register indexes and helper functions for the ranging sensor model.
// Used by tzs_regs, tzs_ctrl, tzs_dp and the top level; depends on nothing.
package tzs_pkg;

    localparam int unsigned PADDR_W = 5;
    localparam logic [6:0]  NO_ZONE = 7'd64;

    localparam logic [2:0] REG_FREQ  = 3'd0;
    localparam logic [2:0] REG_DELAY = 3'd1;
    localparam logic [2:0] REG_AUTO  = 3'd2;
    localparam logic [2:0] REG_STALE = 3'd3;
    localparam logic [2:0] REG_MAXD  = 3'd4;

    // Target status codes that count as a usable measurement.
    localparam logic [7:0] STAT_VALID       = 8'd5;
    localparam logic [7:0] STAT_NO_WRAP     = 8'd6;
    localparam logic [7:0] STAT_LARGE_PULSE = 8'd9;
    localparam logic [7:0] STAT_MERGED      = 8'd12;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        enabled;
        logic        powered;
        logic        ack;
        logic        bus_ok;
        logic        reset_req;
        logic        ranging_on;
        logic        stall_frames;
        logic [15:0] base_dist_mm;
        logic [6:0]  injected_zone;
        logic [15:0] injected_distance_mm;
        logic [7:0]  injected_status;
    } tzs_in_t;

    typedef struct packed {
        logic        active;
        logic        ready_res;
        logic        reinit_busy;
        logic        fresh;
        logic [31:0] age_ms;
        logic [9:0]  period_ms;
        logic [6:0]  valid_zones;
        logic [15:0] nearest_mm;
        logic [15:0] frame_base_mm;
        logic [6:0]  frame_zone;
        logic [15:0] frame_zone_mm;
        logic [7:0]  frame_zone_status;
    } tzs_out_t;

    typedef struct packed {
        logic [7:0]  rate_hz;
        logic [15:0] restart_delay_ms;
        logic        auto_restart;
        logic [15:0] stale_min_ms;
        logic [15:0] max_distance_mm;
    } tzs_cfg_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic report;
    } tzs_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_REPORT,
        ST_OUT
    } tzs_state_t;

    // Frame period in ms for the requested rate, clamped to 1..15 Hz.
    function automatic logic [9:0] period_of(input logic [7:0] hz);
        logic [9:0] p;
        case (hz)
            8'd0, 8'd1: p = 10'd1000;
            8'd2:       p = 10'd500;
            8'd3:       p = 10'd333;
            8'd4:       p = 10'd250;
            8'd5:       p = 10'd200;
            8'd6:       p = 10'd166;
            8'd7:       p = 10'd142;
            8'd8:       p = 10'd125;
            8'd9:       p = 10'd111;
            8'd10:      p = 10'd100;
            8'd11:      p = 10'd90;
            8'd12:      p = 10'd83;
            8'd13:      p = 10'd76;
            8'd14:      p = 10'd71;
            default:    p = 10'd66;
        endcase
        return p;
    endfunction

    function automatic logic status_ok(input logic [7:0] s);
        return s inside {STAT_VALID, STAT_NO_WRAP, STAT_LARGE_PULSE, STAT_MERGED};
    endfunction

    function automatic logic dist_ok(input logic [15:0] d, input logic [15:0] maxd);
        return (d >= 16'd2) && (d <= maxd);
    endfunction

endpackage

@@ design/tzs_regs.sv @@
// APB-style configuration register file of the ranging sensor model.
// Depends on tzs_pkg for the register indexes and the configuration struct.
module tzs_regs
    import tzs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tzs_cfg_t           cfg
);

    tzs_cfg_t   cfg_reg;
    tzs_cfg_t   cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index = paddr[PADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_FREQ:  cfg_next.rate_hz          = pwdata[7:0];
                REG_DELAY: cfg_next.restart_delay_ms = pwdata[15:0];
                REG_AUTO:  cfg_next.auto_restart     = pwdata[0];
                REG_STALE: cfg_next.stale_min_ms     = pwdata[15:0];
                REG_MAXD:  cfg_next.max_distance_mm  = pwdata[15:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_FREQ:  prdata = {24'd0, cfg_reg.rate_hz};
            REG_DELAY: prdata = {16'd0, cfg_reg.restart_delay_ms};
            REG_AUTO:  prdata = {31'd0, cfg_reg.auto_restart};
            REG_STALE: prdata = {16'd0, cfg_reg.stale_min_ms};
            REG_MAXD:  prdata = {16'd0, cfg_reg.max_distance_mm};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_hz          <= 8'd15;
            cfg_reg.restart_delay_ms <= 16'd0;
            cfg_reg.auto_restart     <= 1'b1;
            cfg_reg.stale_min_ms     <= 16'd500;
            cfg_reg.max_distance_mm  <= 16'd4000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/tzs_ctrl.sv @@
// Sequencing state machine of the ranging sensor model: accept, update, report, hand over.
// Depends on tzs_pkg for the state and command types.
module tzs_ctrl
    import tzs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tick_valid,
    output logic     tick_ready,
    output logic     report_valid,
    input  logic     report_ready,
    output tzs_cmd_t cmd
);

    tzs_state_t state_reg;
    tzs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tick_ready   = 1'b0;
        report_valid = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready  = 1'b1;
                cmd.capture = tick_valid;
                if (tick_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                report_valid = 1'b1;
                if (report_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/tzs_dp.sv @@
// Datapath of the ranging sensor model: runtime state, held frame and the result register.
// Depends on tzs_pkg and on the assertion macros header.
`include "tof_zone_sensor_model_macros.svh"
module tzs_dp
    import tzs_pkg::*;
#(
    parameter int unsigned ZONE_COUNT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tzs_cmd_t cmd,
    input  tzs_cfg_t cfg,
    input  tzs_in_t  tick,
    output tzs_out_t report
);

    localparam logic [6:0] ZC = 7'(ZONE_COUNT);

    tzs_in_t     tick_reg;
    tzs_out_t    report_reg;
    tzs_out_t    report_next;

    logic        init_reg, init_next;
    logic        reinit_reg, reinit_next;
    logic        has_frame_reg, has_frame_next;
    logic        seen_reg, seen_next;
    logic [31:0] ready_time_reg, ready_time_next;
    logic [31:0] last_frame_reg, last_frame_next;
    logic [31:0] last_gen_reg, last_gen_next;
    logic [15:0] base_mm_reg, base_mm_next;
    logic [6:0]  zone_reg, zone_next;
    logic [15:0] zone_mm_reg, zone_mm_next;
    logic [7:0]  zone_st_reg, zone_st_next;

    logic [9:0]  period;
    logic        dev_ok, clr, start, done, gen;
    logic        i1, r1, hf1, r2, hf2, i3, r3, hf3;
    logic [31:0] rt1, lf1, lg1, rt2, lg3;
    logic [32:0] ready_sum;
    logic        ready_hit;
    logic [31:0] since_gen;

    logic [11:0] p12, thr3;
    logic [15:0] thr;
    logic [31:0] age;
    logic        inj, base_ok, inj_ok;
    logic [6:0]  base_n;

    assign period    = period_of(cfg.rate_hz);
    assign dev_ok    = tick_reg.powered && tick_reg.ack && tick_reg.bus_ok;
    assign ready_sum = {1'b0, tick_reg.now_ms} + {17'd0, cfg.restart_delay_ms};
    assign since_gen = tick_reg.now_ms - last_gen_reg;

    // The update runs the sensor's steps in order; a ready time set in this same update
    // is reached at once only when the delay is zero or the sum wrapped past zero.
    always_comb
    begin
        clr   = !tick_reg.powered || (tick_reg.reset_req && !seen_reg)
              || (!dev_ok && (init_reg || reinit_reg));
        i1    = clr ? 1'b0  : init_reg;
        r1    = clr ? 1'b0  : reinit_reg;
        hf1   = clr ? 1'b0  : has_frame_reg;
        rt1   = clr ? 32'd0 : ready_time_reg;
        lf1   = clr ? 32'd0 : last_frame_reg;
        lg1   = clr ? 32'd0 : last_gen_reg;

        start = !i1 && !r1 && cfg.auto_restart && dev_ok;
        r2    = r1 || start;
        hf2   = start ? 1'b0 : hf1;
        rt2   = start ? ready_sum[31:0] : rt1;
        ready_hit = start ? ((cfg.restart_delay_ms == 16'd0) || ready_sum[32])
                          : (tick_reg.now_ms >= rt1);

        done  = r2 && dev_ok && ready_hit;
        r3    = r2 && !done;
        i3    = i1 || done;
        hf3   = done ? 1'b0 : hf2;
        lg3   = done ? tick_reg.now_ms : lg1;

        // With a frame already held, nothing was cleared this update, so the old
        // generation time is the one to measure from.
        gen   = i3 && dev_ok && tick_reg.ranging_on && !tick_reg.stall_frames
              && (!hf3 || (since_gen >= {22'd0, period}));

        init_next       = init_reg;
        reinit_next     = reinit_reg;
        has_frame_next  = has_frame_reg;
        seen_next       = seen_reg;
        ready_time_next = ready_time_reg;
        last_frame_next = last_frame_reg;
        last_gen_next   = last_gen_reg;
        base_mm_next    = base_mm_reg;
        zone_next       = zone_reg;
        zone_mm_next    = zone_mm_reg;
        zone_st_next    = zone_st_reg;

        if (cmd.update)
        begin
            if (!tick_reg.enabled)
            begin
                init_next       = 1'b0;
                reinit_next     = 1'b0;
                has_frame_next  = 1'b0;
                seen_next       = 1'b0;
                ready_time_next = 32'd0;
                last_frame_next = 32'd0;
                last_gen_next   = 32'd0;
            end
            else
            begin
                seen_next       = tick_reg.reset_req;
                init_next       = i3;
                reinit_next     = r3;
                has_frame_next  = hf3 || gen;
                ready_time_next = rt2;
                last_frame_next = gen ? tick_reg.now_ms : lf1;
                last_gen_next   = gen ? tick_reg.now_ms : lg3;
                if (gen)
                begin
                    base_mm_next = tick_reg.base_dist_mm;
                    if (tick_reg.injected_zone < ZC)
                    begin
                        zone_next    = tick_reg.injected_zone;
                        zone_mm_next = tick_reg.injected_distance_mm;
                        zone_st_next = tick_reg.injected_status;
                    end
                    else
                    begin
                        zone_next    = NO_ZONE;
                        zone_mm_next = 16'd0;
                        zone_st_next = 8'd0;
                    end
                end
            end
        end
    end

    // Every non-injected zone shares one distance and status 5, so the count is closed form.
    always_comb
    begin
        p12     = {2'b00, period};
        thr3    = p12 + {p12[10:0], 1'b0};
        thr     = (cfg.stale_min_ms > {4'd0, thr3}) ? cfg.stale_min_ms : {4'd0, thr3};
        age     = has_frame_reg ? (tick_reg.now_ms - last_frame_reg) : 32'hFFFF_FFFF;
        inj     = zone_reg < ZC;
        base_n  = inj ? (ZC - 7'd1) : ZC;
        base_ok = has_frame_reg && dist_ok(base_mm_reg, cfg.max_distance_mm);
        inj_ok  = has_frame_reg && inj && status_ok(zone_st_reg)
                  && dist_ok(zone_mm_reg, cfg.max_distance_mm);

        report_next = report_reg;
        if (cmd.report)
        begin
            report_next.period_ms = period;
            if (!tick_reg.enabled)
            begin
                report_next.active            = 1'b0;
                report_next.ready_res         = 1'b1;
                report_next.reinit_busy       = 1'b0;
                report_next.fresh             = 1'b1;
                report_next.age_ms            = 32'hFFFF_FFFF;
                report_next.valid_zones       = ZC;
                report_next.nearest_mm        = tick_reg.base_dist_mm;
                report_next.frame_base_mm     = tick_reg.base_dist_mm;
                report_next.frame_zone        = NO_ZONE;
                report_next.frame_zone_mm     = 16'd0;
                report_next.frame_zone_status = 8'd0;
            end
            else
            begin
                report_next.active            = 1'b1;
                report_next.ready_res         = init_reg;
                report_next.reinit_busy       = reinit_reg;
                report_next.fresh             = has_frame_reg && (age <= {16'd0, thr});
                report_next.age_ms            = age;
                report_next.valid_zones       = (base_ok ? base_n : 7'd0) + {6'd0, inj_ok};
                if (base_ok && inj_ok)
                begin
                    report_next.nearest_mm = (zone_mm_reg < base_mm_reg) ? zone_mm_reg
                                                                         : base_mm_reg;
                end
                else if (base_ok)
                begin
                    report_next.nearest_mm = base_mm_reg;
                end
                else if (inj_ok)
                begin
                    report_next.nearest_mm = zone_mm_reg;
                end
                else
                begin
                    report_next.nearest_mm = 16'd0;
                end
                report_next.frame_base_mm     = base_mm_reg;
                report_next.frame_zone        = zone_reg;
                report_next.frame_zone_mm     = zone_mm_reg;
                report_next.frame_zone_status = zone_st_reg;
            end
        end
    end

    assign report = report_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tick_reg <= tick;
        end
        report_reg <= report_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg       <= 1'b0;
            reinit_reg     <= 1'b0;
            has_frame_reg  <= 1'b0;
            seen_reg       <= 1'b0;
            ready_time_reg <= 32'd0;
            last_frame_reg <= 32'd0;
            last_gen_reg   <= 32'd0;
            base_mm_reg    <= 16'd0;
            zone_reg       <= NO_ZONE;
            zone_mm_reg    <= 16'd0;
            zone_st_reg    <= 8'd0;
        end
        else
        begin
            init_reg       <= init_next;
            reinit_reg     <= reinit_next;
            has_frame_reg  <= has_frame_next;
            seen_reg       <= seen_next;
            ready_time_reg <= ready_time_next;
            last_frame_reg <= last_frame_next;
            last_gen_reg   <= last_gen_next;
            base_mm_reg    <= base_mm_next;
            zone_reg       <= zone_next;
            zone_mm_reg    <= zone_mm_next;
            zone_st_reg    <= zone_st_next;
        end
    end

    `TZS_ASSERT_NOW(a_state_exclusive, init_reg, !reinit_reg, "initialized and reinitializing together")
    `TZS_ASSERT_NOW(a_frame_needs_init, has_frame_reg, init_reg, "frame held while not initialized")
    `TZS_ASSERT_NOW(a_zone_range, 1'b1, zone_reg <= NO_ZONE, "held zone beyond the no-zone code")
    `TZS_ASSERT_NEXT(a_update_quiet, !cmd.update, $stable(init_reg) && $stable(has_frame_reg), "runtime state moved outside an update")

endmodule

@@ design/tof_zone_sensor_model.sv @@
// Top level of the multizone ranging sensor model: register file, controller and datapath.
// Depends on tzs_pkg, tzs_regs, tzs_ctrl and tzs_dp.
//
//  channel   handshake                        payload
//  tick      tick_valid / tick_ready          tick   (tzs_in_t)
//  report    report_valid / report_ready      report (tzs_out_t)
//  config    psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// Each item goes through accept, state update and result calculation, then the result
// register is offered until it is taken.
// One item is in flight at a time; a stalled report holds off the next item.
// The frame period comes from a constant table, so no divider is needed.
// Async rst_n clears all but the tick and result registers; no clearing pass is required.
module tof_zone_sensor_model
    import tzs_pkg::*;
#(
    parameter int unsigned ZONE_COUNT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    input  tzs_in_t            tick,
    output logic               report_valid,
    input  logic               report_ready,
    output tzs_out_t           report,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tzs_cfg_t cfg;
    tzs_cmd_t cmd;

    tzs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tzs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .cmd          (cmd)
    );

    tzs_dp #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .tick   (tick),
        .report (report)
    );

endmodule

@@ bench/tzs_report_checker.sv @@
// Report checker for the ranging sensor model: watches the tick, report and register ports,
// predicts each report from its own copy of the sensor state and compares field by field.
// Depends on tzs_pkg for the payload types, register indexes, status codes and no-zone code.
module tzs_report_checker
    import tzs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    input  logic               tick_ready,
    input  tzs_in_t            tick,
    input  logic               report_valid,
    input  logic               report_ready,
    input  tzs_out_t           report,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fault_count,
    output int                 reports_due_n
);

    localparam int ZONES = 64;

    // Register copy, updated from the writes seen on the register port.
    logic [7:0]  set_hz;
    logic [15:0] set_delay;
    logic        set_auto;
    logic [15:0] set_stale;
    logic [15:0] set_maxd;

    // Sensor state as the block should hold it.
    logic        initialised;
    logic        reinit_active;
    logic        frame_held;
    logic        reset_level;
    logic [31:0] ready_at;
    logic [31:0] frame_at;
    logic [31:0] gen_at;
    logic [15:0] held_base;
    logic [6:0]  held_zone;
    logic [15:0] held_zone_mm;
    logic [7:0]  held_zone_st;

    tzs_out_t reports_due[$];
    int       faults = 0;

    function automatic logic status_counts(input logic [7:0] s);
        case (s)
            STAT_VALID, STAT_NO_WRAP, STAT_LARGE_PULSE, STAT_MERGED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic distance_counts(input logic [15:0] d);
        return (d >= 16'd2) && (d <= set_maxd);
    endfunction

    function automatic void drop_runtime();
        initialised   = 1'b0;
        reinit_active = 1'b0;
        frame_held    = 1'b0;
        ready_at      = '0;
        frame_at      = '0;
        gen_at        = '0;
    endfunction

    // Advances the sensor state by one tick and returns the report it should produce.
    function automatic tzs_out_t range_tick(input tzs_in_t t);
        logic [7:0]  hz;
        logic [9:0]  per;
        logic [31:0] age;
        logic [31:0] stale_at;
        logic [6:0]  n_valid;
        logic [15:0] lo;
        logic        rise;
        logic        link_ok;
        logic        fresh;
        logic        has_inj;
        tzs_out_t    r;

        hz = set_hz;
        if (hz == 8'd0)
            hz = 8'd1;
        else if (hz > 8'd15)
            hz = 8'd15;
        per = 10'(32'd1000 / 32'(hz));
        r = '0;
        r.period_ms = per;

        // Bypass: ideal all-valid frame; held frame contents kept, runtime state and frame flag dropped.
        if (!t.enabled)
        begin
            drop_runtime();
            reset_level     = 1'b0;
            r.ready_res     = 1'b1;
            r.fresh         = 1'b1;
            r.age_ms        = '1;
            r.valid_zones   = 7'(ZONES);
            r.nearest_mm    = t.base_dist_mm;
            r.frame_base_mm = t.base_dist_mm;
            r.frame_zone    = NO_ZONE;
            return r;
        end

        rise        = t.reset_req && !reset_level;
        reset_level = t.reset_req;
        link_ok     = t.powered && t.ack && t.bus_ok;

        if (!t.powered)
        begin
            drop_runtime();
        end
        else
        begin
            if (rise)
                drop_runtime();
            if (!link_ok && (initialised || reinit_active))
                drop_runtime();
            if (!initialised && !reinit_active && set_auto && link_ok)
            begin
                reinit_active = 1'b1;
                frame_held    = 1'b0;
                ready_at      = t.now_ms + 32'(set_delay);
            end
            // A ready time that wrapped past zero completes straight away.
            if (reinit_active && link_ok && t.now_ms >= ready_at)
            begin
                reinit_active = 1'b0;
                initialised   = 1'b1;
                frame_held    = 1'b0;
                gen_at        = t.now_ms;
            end
            if (initialised && link_ok && t.ranging_on && !t.stall_frames)
            begin
                if (!frame_held || (t.now_ms - gen_at) >= 32'(per))
                begin
                    held_base = t.base_dist_mm;
                    if (t.injected_zone < 7'(ZONES))
                    begin
                        held_zone    = t.injected_zone;
                        held_zone_mm = t.injected_distance_mm;
                        held_zone_st = t.injected_status;
                    end
                    else
                    begin
                        held_zone    = NO_ZONE;
                        held_zone_mm = '0;
                        held_zone_st = '0;
                    end
                    frame_held = 1'b1;
                    frame_at   = t.now_ms;
                    gen_at     = t.now_ms;
                end
            end
        end

        if (frame_held)
        begin
            has_inj  = held_zone < 7'(ZONES);
            n_valid  = '0;
            lo       = 16'hFFFF;
            age      = t.now_ms - frame_at;
            stale_at = 32'(per) * 32'd3;
            if (32'(set_stale) > stale_at)
                stale_at = 32'(set_stale);
            fresh = age <= stale_at;
            if (distance_counts(held_base))
            begin
                n_valid = has_inj ? 7'(ZONES - 1) : 7'(ZONES);
                lo      = held_base;
            end
            if (has_inj && status_counts(held_zone_st) && distance_counts(held_zone_mm))
            begin
                n_valid = n_valid + 7'd1;
                if (held_zone_mm < lo)
                    lo = held_zone_mm;
            end
            r.valid_zones = n_valid;
            r.nearest_mm  = (n_valid != 7'd0) ? lo : 16'd0;
        end
        else
        begin
            age   = '1;
            fresh = 1'b0;
        end

        r.active            = 1'b1;
        r.ready_res         = initialised;
        r.reinit_busy       = reinit_active;
        r.fresh             = fresh;
        r.age_ms            = age;
        r.frame_base_mm     = held_base;
        r.frame_zone        = held_zone;
        r.frame_zone_mm     = held_zone_mm;
        r.frame_zone_status = held_zone_st;
        return r;
    endfunction

    task automatic mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("tzs_report_checker: %s wrong at %0t, got %0h, expected %0h",
                 field, $time, got, want);
        faults++;
    endtask

    task automatic compare_report(input tzs_out_t got, input tzs_out_t want);
        if (got.active !== want.active)
            mismatch("active", 32'(got.active), 32'(want.active));
        if (got.ready_res !== want.ready_res)
            mismatch("ready_res", 32'(got.ready_res), 32'(want.ready_res));
        if (got.reinit_busy !== want.reinit_busy)
            mismatch("reinit_busy", 32'(got.reinit_busy), 32'(want.reinit_busy));
        if (got.fresh !== want.fresh)
            mismatch("fresh", 32'(got.fresh), 32'(want.fresh));
        if (got.age_ms !== want.age_ms)
            mismatch("age_ms", got.age_ms, want.age_ms);
        if (got.period_ms !== want.period_ms)
            mismatch("period_ms", 32'(got.period_ms), 32'(want.period_ms));
        if (got.valid_zones !== want.valid_zones)
            mismatch("valid_zones", 32'(got.valid_zones), 32'(want.valid_zones));
        if (got.nearest_mm !== want.nearest_mm)
            mismatch("nearest_mm", 32'(got.nearest_mm), 32'(want.nearest_mm));
        if (got.frame_base_mm !== want.frame_base_mm)
            mismatch("frame_base_mm", 32'(got.frame_base_mm), 32'(want.frame_base_mm));
        if (got.frame_zone !== want.frame_zone)
            mismatch("frame_zone", 32'(got.frame_zone), 32'(want.frame_zone));
        if (got.frame_zone_mm !== want.frame_zone_mm)
            mismatch("frame_zone_mm", 32'(got.frame_zone_mm), 32'(want.frame_zone_mm));
        if (got.frame_zone_status !== want.frame_zone_status)
            mismatch("frame_zone_status", 32'(got.frame_zone_status),
                     32'(want.frame_zone_status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_hz        = 8'd15;
            set_delay     = 16'd0;
            set_auto      = 1'b1;
            set_stale     = 16'd500;
            set_maxd      = 16'd4000;
            drop_runtime();
            reset_level   = 1'b0;
            held_base     = '0;
            held_zone     = NO_ZONE;
            held_zone_mm  = '0;
            held_zone_st  = '0;
            reports_due.delete();
            reports_due_n <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_FREQ:  set_hz    = pwdata[7:0];
                    REG_DELAY: set_delay = pwdata[15:0];
                    REG_AUTO:  set_auto  = pwdata[0];
                    REG_STALE: set_stale = pwdata[15:0];
                    REG_MAXD:  set_maxd  = pwdata[15:0];
                    default: ;
                endcase
            end
            // Retire the oldest report before a new tick queues its own.
            if (report_valid && report_ready)
            begin
                if (reports_due.size() == 0)
                    mismatch("report with none expected", 32'd1, 32'd0);
                else
                    compare_report(report, reports_due.pop_front());
            end
            if (tick_valid && tick_ready)
                reports_due.push_back(range_tick(tick));
            reports_due_n <= reports_due.size();
            fault_count   <= faults;
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the ranging sensor model bench: clock, reset, tick stimulus, report back-pressure
// and register writes. Depends on tzs_pkg, tof_zone_sensor_model and tzs_report_checker.
module tb_top;
    import tzs_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               tick_valid   = 1'b0;
    tzs_in_t            tick         = '0;
    logic               report_ready = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic               tick_ready;
    logic               report_valid;
    tzs_out_t           report;
    logic [31:0]        prdata;
    logic               pready;

    int          fault_count;
    int          reports_due_n;
    logic [31:0] clock_ms   = '0;
    int          stall_run  = 0;
    int          stall_mode = 0;

    always #10 clk = ~clk;

    tof_zone_sensor_model dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tzs_report_checker watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_ready    (tick_ready),
        .tick          (tick),
        .report_valid  (report_valid),
        .report_ready  (report_ready),
        .report        (report),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fault_count   (fault_count),
        .reports_due_n (reports_due_n)
    );

    // Report back-pressure: runs of always ready, coin-toss ready and long stalls.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(20, 200);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       report_ready <= 1'b1;
            1:       report_ready <= ($urandom_range(0, 1) == 1);
            default: report_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic push_tick(input tzs_in_t t);
        tick       <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every report owed has been taken.
    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (reports_due_n != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_distance();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 16'($urandom_range(0, 3));
        else if (pick < 65)
            return 16'($urandom_range(0, 4100));
        return 16'($urandom());
    endfunction

    // Mostly a healthy, ranging sensor with random frame contents; the rest is noise.
    function automatic tzs_in_t make_tick();
        int      pick;
        tzs_in_t t;
        t = '0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms += $urandom_range(0, 30);
        else if (pick < 85)
            clock_ms += $urandom_range(31, 400);
        else if (pick < 97)
            clock_ms += $urandom_range(401, 70000);
        else
            clock_ms = $urandom();
        t.now_ms = clock_ms;
        if ($urandom_range(0, 4) != 0)
        begin
            t.enabled      = 1'b1;
            t.powered      = 1'b1;
            t.ack          = 1'b1;
            t.bus_ok       = 1'b1;
            t.reset_req    = ($urandom_range(0, 29) == 0);
            t.ranging_on   = 1'b1;
            t.stall_frames = ($urandom_range(0, 9) == 0);
        end
        else
        begin
            t.enabled      = ($urandom_range(0, 3) != 0);
            t.powered      = ($urandom_range(0, 3) != 0);
            t.ack          = ($urandom_range(0, 3) != 0);
            t.bus_ok       = ($urandom_range(0, 3) != 0);
            t.reset_req    = ($urandom_range(0, 1) == 1);
            t.ranging_on   = ($urandom_range(0, 3) != 0);
            t.stall_frames = ($urandom_range(0, 3) == 0);
        end
        t.base_dist_mm = pick_distance();
        pick = $urandom_range(0, 9);
        if (pick < 5)
            t.injected_zone = 7'($urandom_range(0, 63));
        else if (pick < 8)
            t.injected_zone = 7'($urandom_range(64, 127));
        else
            t.injected_zone = 7'($urandom());
        t.injected_distance_mm = pick_distance();
        // The low range hits the valid status codes often enough.
        if ($urandom_range(0, 1) == 1)
            t.injected_status = 8'($urandom_range(0, 15));
        else
            t.injected_status = 8'($urandom());
        return t;
    endfunction

    task automatic run_phase(input logic [7:0] hz, input logic [15:0] delay, input logic auto_on,
                             input logic [15:0] stale, input logic [15:0] maxd,
                             input logic jump, input logic [31:0] start, input int n);
        int sent;
        int burst;
        int gap;
        settle();
        write_reg(REG_FREQ, {24'($urandom()), hz});
        write_reg(REG_DELAY, {16'($urandom()), delay});
        write_reg(REG_AUTO, {31'($urandom()), auto_on});
        write_reg(REG_STALE, {16'($urandom()), stale});
        write_reg(REG_MAXD, {16'($urandom()), maxd});
        write_reg(REG_SPARE, $urandom());
        if (jump)
            clock_ms = start;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < n)
            begin
                push_tick(make_tick());
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        tzs_in_t base;
        tzs_in_t t;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values.
        base = '0;
        base.now_ms        = 32'd100;
        base.enabled       = 1'b1;
        base.powered       = 1'b1;
        base.ack           = 1'b1;
        base.bus_ok        = 1'b1;
        base.ranging_on    = 1'b1;
        base.base_dist_mm  = 16'd1000;
        base.injected_zone = NO_ZONE;

        t = base; t.enabled = 1'b0; push_tick(t);
        t = base; t.powered = 1'b0; push_tick(t);
        t = base; t.ack = 1'b0;     push_tick(t);
        t = base; t.bus_ok = 1'b0;  push_tick(t);
        push_tick(base);

        base.now_ms += 32'd70;
        t = base; t.injected_zone = 7'd0; t.injected_distance_mm = 16'd2;
        t.injected_status = STAT_VALID;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.injected_zone = 7'd63; t.injected_distance_mm = 16'd4000;
        t.injected_status = STAT_NO_WRAP; t.base_dist_mm = 16'd4001;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.injected_zone = 7'd5; t.injected_distance_mm = 16'd1;
        t.injected_status = STAT_LARGE_PULSE; t.base_dist_mm = 16'd2;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.injected_zone = 7'd10; t.injected_distance_mm = 16'hFFFF;
        t.injected_status = STAT_MERGED; t.base_dist_mm = 16'hFFFF;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.injected_zone = 7'd10; t.injected_distance_mm = 16'd100;
        t.injected_status = '1; t.base_dist_mm = 16'd100;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.injected_zone = '1; t.base_dist_mm = 16'd0;
        push_tick(t);
        base.now_ms += 32'd70;
        t = base; t.base_dist_mm = 16'd3;
        push_tick(t);

        // Frame suppression, then ranging off long enough for the frame to go stale.
        base.now_ms += 32'd70;
        t = base; t.stall_frames = 1'b1; push_tick(t);
        base.now_ms += 32'd600;
        t = base; t.ranging_on = 1'b0; push_tick(t);

        // A reset request acts on its rising edge only.
        base.now_ms += 32'd10;
        t = base; t.reset_req = 1'b1; push_tick(t);
        base.now_ms += 32'd70;
        push_tick(t);
        base.now_ms += 32'd70;
        push_tick(base);

        // Time wrapping through zero.
        base.now_ms = 32'hFFFF_FFF0;
        push_tick(base);
        base.now_ms = 32'd20;
        push_tick(base);
        t = base; t.enabled = 1'b0; t.base_dist_mm = 16'hFFFF; push_tick(t);

        clock_ms = base.now_ms;
        run_phase(8'd0, 16'd0, 1'b1, 16'd0, 16'hFFFF, 1'b0, 32'd0, 160);
        run_phase(8'd255, 16'd20, 1'b1, 16'hFFFF, 16'd0, 1'b0, 32'd0, 160);
        // Long reinit delay starting just below the wrap point.
        run_phase(8'd1, 16'hFFFF, 1'b1, 16'd500, 16'd4000, 1'b1, 32'hFFFF_FF00, 160);
        run_phase(8'd16, 16'd5, 1'b0, 16'd100, 16'd2, 1'b0, 32'd0, 60);
        run_phase(8'd7, 16'd300, 1'b1, 16'd1, 16'd1, 1'b0, 32'd0, 160);
        run_phase(8'd14, 16'd1, 1'b1, 16'd0, 16'd3000, 1'b0, 32'd0, 160);
        run_phase(8'd3, 16'd0, 1'b1, 16'd200, 16'hFFFF, 1'b1, 32'hFFFF_F000, 160);
        run_phase(8'($urandom()), 16'($urandom_range(0, 2000)), 1'b1, 16'($urandom()),
                  16'($urandom()), 1'b0, 32'd0, 200);

        settle();
        repeat (8) @(posedge clk);
        if (fault_count == 0 && reports_due_n == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/tzs_pkg.sv
design/tzs_regs.sv
design/tzs_ctrl.sv
design/tzs_dp.sv
design/tof_zone_sensor_model.sv
bench/tzs_report_checker.sv
bench/tb_top.sv
